/* rtl/rptd_pkg.sv */
`default_nettype none

package rptd_pkg;

  localparam int unsigned MAG_BITS_DEF = 31;
  localparam int unsigned DURATION_W   = 31;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [POS_W-1:0] PREFIX_LEN  = 4'd9;
  localparam logic [POS_W-1:0] PREFIX_MISS = 4'd15;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_PULSE  = 2'd0,
    KIND_END    = 2'd1,
    KIND_NODATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HEAD    = 2'd0,
    MODE_PARSE   = 2'd1,
    MODE_ABANDON = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  typedef struct packed {
    kind_e                 kind;
    logic [DURATION_W-1:0] duration;
    logic                  level;
    logic                  last;
  } result_t;

  // expected character of the raw line prefix
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h52;
      4'd1:    ch = 8'h41;
      4'd2:    ch = 8'h57;
      4'd3:    ch = 8'h5F;
      4'd4:    ch = 8'h44;
      4'd5:    ch = 8'h61;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h61;
      4'd8:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
           (ch == CH_VT) || (ch == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

/* rtl/raw_pulse_text_decoder_unit.sv */
// a byte's results are written into the result queue at its transaction
// one byte per cycle while in_stall_o is low; a byte with two results queues both, sent in order
// in_stall_o is high while the result queue has fewer than two free entries
// rst_ni (asynchronous, active low) returns to searching for the first raw line
// and empties the result queue
`default_nettype none

module raw_pulse_text_decoder_unit #(
  parameter int unsigned MAGNITUDE_BITS = rptd_pkg::MAG_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [7:0]                       text_byte_i,
  input  wire                              end_of_file_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [rptd_pkg::KIND_W-1:0]      kind_o,
  output logic [rptd_pkg::DURATION_W-1:0]  duration_o,
  output logic                             level_o,
  output logic                             last_o
);
  import rptd_pkg::*;

  localparam int unsigned PROD_W = MAGNITUDE_BITS + 4;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PROD_W-1:0] MAG_MAX = {4'b0000, {MAGNITUDE_BITS{1'b1}}};
  localparam logic [CNT_W-1:0]  STALL_LEVEL = CNT_W'(QUEUE_DEPTH - 2);

  mode_e                     mode_q, mode_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [MAGNITUDE_BITS-1:0] acc_q, acc_d;
  logic                      neg_q, neg_d;
  logic                      dig_q, dig_d;
  logic                      nonempty_q, nonempty_d;
  logic                      found_q, found_d;

  result_t                   queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic                      in_accept, out_accept;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         acc_wide;
  result_t                   res [2];
  logic [1:0]                n_res;

  function automatic result_t make_result(input kind_e k,
                                          input logic [MAGNITUDE_BITS-1:0] dur,
                                          input logic lvl);
    result_t r;
    r.kind     = k;
    r.duration = DURATION_W'(dur);
    r.level    = lvl;
    r.last     = 1'b0;
    return r;
  endfunction

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;
  assign in_stall_o = cnt_q > STALL_LEVEL;

  // acc * 10 + digit as two shifted adds
  assign acc_wide = PROD_W'(acc_q);
  assign prod = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(text_byte_i[3:0]);

  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    dig_d      = dig_q;
    nonempty_d = nonempty_q;
    found_d    = found_q;
    n_res      = 2'd0;
    res[0]     = make_result(KIND_PULSE, '0, 1'b0);
    res[1]     = make_result(KIND_PULSE, '0, 1'b0);

    if (in_accept) begin
      if (text_byte_i != CH_LF) begin
        unique case (mode_q)
          MODE_HEAD: begin
            if (pos_q != '0 || text_byte_i != CH_CR) nonempty_d = 1'b1;
            if (pos_q < PREFIX_LEN && text_byte_i == prefix_char(pos_q)) begin
              pos_d = pos_q + 1'b1;
              if (pos_d == PREFIX_LEN) begin
                mode_d  = MODE_PARSE;
                found_d = 1'b1;
                acc_d   = '0;
                neg_d   = 1'b0;
                dig_d   = 1'b0;
              end
            end else begin
              pos_d = PREFIX_MISS;
            end
          end
          MODE_PARSE: begin
            if (is_digit(text_byte_i)) begin
              acc_d = (prod > MAG_MAX) ? MAG_MAX[MAGNITUDE_BITS-1:0]
                                       : prod[MAGNITUDE_BITS-1:0];
              dig_d = 1'b1;
            end else if (text_byte_i == CH_MINUS) begin
              if (dig_q) begin
                if (acc_q != '0) begin
                  res[0] = make_result(KIND_PULSE, acc_q, !neg_q);
                  n_res  = 2'd1;
                end
                acc_d = '0;
                dig_d = 1'b0;
                neg_d = 1'b1;
              end else if (neg_q) begin
                mode_d = MODE_ABANDON;
              end else begin
                neg_d = 1'b1;
              end
            end else if (is_blank(text_byte_i)) begin
              if (dig_q) begin
                if (acc_q != '0) begin
                  res[0] = make_result(KIND_PULSE, acc_q, !neg_q);
                  n_res  = 2'd1;
                end
                acc_d = '0;
                dig_d = 1'b0;
                neg_d = 1'b0;
              end else if (neg_q) begin
                mode_d = MODE_ABANDON;
              end
            end else begin
              // stray character: flush any number, drop the rest of the line
              if (dig_q && acc_q != '0) begin
                res[0] = make_result(KIND_PULSE, acc_q, !neg_q);
                n_res  = 2'd1;
              end
              acc_d  = '0;
              dig_d  = 1'b0;
              neg_d  = 1'b0;
              mode_d = MODE_ABANDON;
            end
          end
          default: ;
        endcase
      end

      // end of line, also taken at end of file without a trailing newline
      if (text_byte_i == CH_LF || end_of_file_i) begin
        unique case (mode_d)
          MODE_HEAD: begin
            if (found_d && nonempty_d) begin
              res[n_res[0]] = make_result(KIND_END, '0, 1'b0);
              n_res         = n_res + 2'd1;
              mode_d        = MODE_DONE;
            end
            pos_d = '0; nonempty_d = 1'b0; acc_d = '0; neg_d = 1'b0; dig_d = 1'b0;
          end
          MODE_PARSE: begin
            if (dig_d && acc_d != '0) begin
              res[n_res[0]] = make_result(KIND_PULSE, acc_d, !neg_d);
              n_res         = n_res + 2'd1;
            end
            mode_d = MODE_HEAD;
            pos_d = '0; nonempty_d = 1'b0; acc_d = '0; neg_d = 1'b0; dig_d = 1'b0;
          end
          MODE_ABANDON: begin
            mode_d = MODE_HEAD;
            pos_d = '0; nonempty_d = 1'b0; acc_d = '0; neg_d = 1'b0; dig_d = 1'b0;
          end
          default: ;
        endcase
      end

      if (end_of_file_i) begin
        if (mode_d != MODE_DONE && n_res != 2'd2) begin
          res[n_res[0]] = make_result(found_d ? KIND_END : KIND_NODATA, '0, 1'b0);
          n_res         = n_res + 2'd1;
        end
        mode_d     = MODE_HEAD;
        found_d    = 1'b0;
        pos_d      = '0;
        nonempty_d = 1'b0;
        acc_d      = '0;
        neg_d      = 1'b0;
        dig_d      = 1'b0;
      end

      if (n_res == 2'd1) res[0].last = 1'b1;
      if (n_res == 2'd2) res[1].last = 1'b1;
    end
  end

  assign cnt_d = cnt_q + CNT_W'(n_res) - CNT_W'(out_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HEAD;
      pos_q      <= '0;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      dig_q      <= 1'b0;
      nonempty_q <= 1'b0;
      found_q    <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      dig_q      <= dig_d;
      nonempty_q <= nonempty_d;
      found_q    <= found_d;
      wr_ptr_q   <= wr_ptr_q + PTR_W'(n_res);
      rd_ptr_q   <= rd_ptr_q + PTR_W'(out_accept);
      cnt_q      <= cnt_d;
    end
  end

  // result queue entries, payload only
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) queue_q[wr_ptr_q] <= res[0];
    if (n_res == 2'd2) queue_q[wr_ptr_q + 1'b1] <= res[1];
  end

  assign out_valid_o = cnt_q != '0;
  assign kind_o      = queue_q[rd_ptr_q].kind;
  assign duration_o  = queue_q[rd_ptr_q].duration;
  assign level_o     = queue_q[rd_ptr_q].level;
  assign last_o      = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

/* rtl/rptd_checker.sv */
`default_nettype none

module rptd_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_stall_o,
  input wire                              out_valid_o,
  input wire                              out_stall_i,
  input wire [rptd_pkg::KIND_W-1:0]       kind_o,
  input wire [rptd_pkg::DURATION_W-1:0]   duration_o,
  input wire                              level_o,
  input wire                              last_o
);
  import rptd_pkg::*;

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(duration_o) &&
      $stable(level_o) && $stable(last_o))
    else $error("result changed while stalled");

  // with nothing queued there is always room for a byte
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty queue");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_PULSE || kind_o == KIND_END || kind_o == KIND_NODATA)
    else $error("illegal result kind");

  // markers carry no duration and always close the byte's results
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_PULSE |-> duration_o == '0 && !level_o && last_o)
    else $error("malformed end marker");

  a_pulse_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PULSE |-> duration_o != '0)
    else $error("zero length pulse");

endmodule

bind raw_pulse_text_decoder_unit rptd_checker u_rptd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .duration_o  (duration_o),
  .level_o     (level_o),
  .last_o      (last_o)
);

`default_nettype wire
